// ===== design/wmmd_pkg.sv =====
// Shared widths, register map and control types for the min/max waveform decimator.
`timescale 1ns / 1ps
`default_nettype none
package wmmd_pkg;

    localparam int SAMPLE_BITS         = 24;
    localparam int MAX_BINS_PER_SAMPLE = 64;

    localparam int SAMPLE_COUNT_W = 24;
    localparam int BIN_COUNT_W    = 16;
    localparam int NUM_W          = SAMPLE_COUNT_W + BIN_COUNT_W;
    localparam int EMIT_CNT_W     = $clog2(MAX_BINS_PER_SAMPLE + 1);

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_SEL_BIT = 2;

    typedef enum logic
    {
        REG_SAMPLE_COUNT = 1'b0,
        REG_BIN_COUNT    = 1'b1
    } reg_sel_t;

    typedef struct packed
    {
        logic [SAMPLE_COUNT_W-1:0] sample_count;
        logic [BIN_COUNT_W-1:0]    bin_count;
        logic                      restart;
    } wmmd_cfg_t;

endpackage
`default_nettype wire

// ===== design/wmmd_sample_if.sv =====
// Input sample channel: valid/ready handshake carrying one audio sample.
`timescale 1ns / 1ps
`default_nettype none
interface wmmd_sample_if;
    import wmmd_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ===== design/wmmd_bin_if.sv =====
// Output bin channel: valid/ready handshake carrying one bin report.
`timescale 1ns / 1ps
`default_nettype none
interface wmmd_bin_if;
    import wmmd_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [BIN_COUNT_W-1:0]        bin_number;
    logic signed [SAMPLE_BITS-1:0] bin_min;
    logic signed [SAMPLE_BITS-1:0] bin_max;
    logic                          last_of_run;
    logic                          frame_done;

    modport source (output valid, output bin_number, output bin_min, output bin_max,
                    output last_of_run, output frame_done, input ready);
    modport sink   (input valid, input bin_number, input bin_min, input bin_max,
                    input last_of_run, input frame_done, output ready);
endinterface
`default_nettype wire

// ===== design/waveform_min_max_decimator.sv =====
// Top level of the min/max waveform decimator.
//
// Usage: program sample_count (byte address 0) and bin_count (byte address 4)
// over the APB port while the block is idle; each write restarts the frame and
// holds the sample channel off for one cycle. Samples enter on sample_in, one
// word per accepted handshake. Bin reports leave on bin_out, each word carrying
// the bin number, its min and max, last_of_run and frame_done.
// A sample accepted at a clock edge is in the sample stage during the next
// cycle, and each bin report it closes is registered in the output register.
// Throughput: one sample per cycle while bin_out takes its words and each
// sample closes at most one bin. A sample that closes more than one bin stays
// in the sample stage, one bin boundary per cycle; past 64 reports the
// remaining bins are dropped, still one per cycle. A zero sample_count or
// bin_count drops every sample. Stall: when bin_out is not taken, the output
// register holds its word and the sample stage holds as soon as it has
// another bin to report; sample_in.ready falls with it.
// Reset: both counts clear to zero, the frame restarts and no word is pending.
`timescale 1ns / 1ps
`default_nettype none
module waveform_min_max_decimator
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [wmmd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [wmmd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [wmmd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    wmmd_sample_if.sink                          sample_in,
    wmmd_bin_if.source                           bin_out
);
    import wmmd_pkg::*;

    wmmd_cfg_t cfg;

    wmmd_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wmmd_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .sample_in (sample_in),
        .bin_out   (bin_out)
    );

endmodule
`default_nettype wire

// ===== design/wmmd_apb_regs.sv =====
// APB register file holding the frame length and bin count.
`timescale 1ns / 1ps
`default_nettype none
module wmmd_apb_regs
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [wmmd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [wmmd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [wmmd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output wmmd_pkg::wmmd_cfg_t                 cfg
);
    import wmmd_pkg::*;

    logic [SAMPLE_COUNT_W-1:0] sample_count_reg;
    logic [BIN_COUNT_W-1:0]    bin_count_reg;
    logic                      restart_reg;
    logic                      wr_en;
    reg_sel_t                  sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = reg_sel_t'(paddr[REG_SEL_BIT]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= '0;
            bin_count_reg    <= '0;
            restart_reg      <= 1'b0;
        end
        else
        begin
            restart_reg <= wr_en;
            if (wr_en)
            begin
                case (sel)
                    REG_SAMPLE_COUNT: sample_count_reg <= pwdata[SAMPLE_COUNT_W-1:0];
                    REG_BIN_COUNT:    bin_count_reg    <= pwdata[BIN_COUNT_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_comb
    begin
        case (sel)
            REG_SAMPLE_COUNT: prdata = {{(APB_DATA_W-SAMPLE_COUNT_W){1'b0}}, sample_count_reg};
            REG_BIN_COUNT:    prdata = {{(APB_DATA_W-BIN_COUNT_W){1'b0}}, bin_count_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.sample_count = sample_count_reg;
    assign cfg.bin_count    = bin_count_reg;
    assign cfg.restart      = restart_reg;

endmodule
`default_nettype wire

// ===== design/wmmd_core.sv =====
// Sample stage, bin boundary tracking and output register of the decimator.
`timescale 1ns / 1ps
`default_nettype none
module wmmd_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wmmd_pkg::wmmd_cfg_t cfg,
    wmmd_sample_if.sink             sample_in,
    wmmd_bin_if.source              bin_out
);
    import wmmd_pkg::*;

    // frame position, tracked at accept time
    logic [SAMPLE_COUNT_W-1:0]     pos_reg;
    logic [NUM_W-1:0]              pn_reg;

    // sample stage
    logic                          busy_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [NUM_W-1:0]              a_reg;
    logic [NUM_W-1:0]              b_reg;
    logic                          end_reg;
    logic [EMIT_CNT_W-1:0]         cnt_reg;

    // bin state
    logic [BIN_COUNT_W-1:0]        bin_reg;
    logic [NUM_W-1:0]              low_reg;
    logic [NUM_W-1:0]              high_reg;
    logic                          open_reg;
    logic signed [SAMPLE_BITS-1:0] run_min_reg;
    logic signed [SAMPLE_BITS-1:0] run_max_reg;

    // output register
    logic                          out_valid_reg;
    logic [BIN_COUNT_W-1:0]        out_bin_reg;
    logic signed [SAMPLE_BITS-1:0] out_min_reg;
    logic signed [SAMPLE_BITS-1:0] out_max_reg;
    logic                          out_last_reg;
    logic                          out_done_reg;

    logic                          cfg_live;
    logic [NUM_W-1:0]              n_ext;
    logic [NUM_W-1:0]              s_ext;
    logic [NUM_W-1:0]              a_in;
    logic [NUM_W-1:0]              b_in;
    logic                          end_in;
    logic                          accept;
    logic signed [SAMPLE_BITS-1:0] eff_min;
    logic signed [SAMPLE_BITS-1:0] eff_max;
    logic [BIN_COUNT_W:0]          bin_inc;
    logic [NUM_W-1:0]              high_inc;
    logic                          close_now;
    logic                          close_more;
    logic                          emit;
    logic                          out_free;
    logic                          step;
    logic                          finish;

    assign cfg_live = (cfg.sample_count != '0) && (cfg.bin_count != '0);
    assign n_ext    = {{(NUM_W-BIN_COUNT_W){1'b0}}, cfg.bin_count};
    assign s_ext    = {{(NUM_W-SAMPLE_COUNT_W){1'b0}}, cfg.sample_count};
    assign a_in     = pn_reg + n_ext;
    assign b_in     = pn_reg + {n_ext[NUM_W-2:0], 1'b0};
    assign end_in   = ({1'b0, pos_reg} + {{SAMPLE_COUNT_W{1'b0}}, 1'b1})
                      >= {1'b0, cfg.sample_count};

    assign eff_min  = (open_reg && (run_min_reg < x_reg)) ? run_min_reg : x_reg;
    assign eff_max  = (open_reg && (run_max_reg > x_reg)) ? run_max_reg : x_reg;

    assign bin_inc    = {1'b0, bin_reg} + {{BIN_COUNT_W{1'b0}}, 1'b1};
    assign high_inc   = high_reg + s_ext;
    assign close_now  = (bin_reg < cfg.bin_count) && (high_reg < b_reg) && (low_reg < a_reg);
    assign close_more = (bin_inc < {1'b0, cfg.bin_count}) && (high_inc < b_reg)
                        && (high_reg < a_reg);

    assign emit     = busy_reg && close_now
                      && (cnt_reg != EMIT_CNT_W'(MAX_BINS_PER_SAMPLE));
    assign out_free = !out_valid_reg || bin_out.ready;
    assign step     = busy_reg && !(emit && !out_free);
    assign finish   = step && (!close_now || !close_more);

    assign sample_in.ready = (!busy_reg || finish) && !cfg.restart;
    assign accept          = sample_in.valid && sample_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            pn_reg   <= '0;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            bin_reg  <= '0;
            low_reg  <= '0;
            high_reg <= '0;
            open_reg <= 1'b0;
        end
        else if (cfg.restart)
        begin
            pos_reg  <= '0;
            pn_reg   <= '0;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            bin_reg  <= '0;
            low_reg  <= '0;
            high_reg <= s_ext;
            open_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                if (close_now)
                begin
                    bin_reg  <= bin_inc[BIN_COUNT_W-1:0];
                    low_reg  <= high_reg;
                    high_reg <= high_inc;
                    open_reg <= 1'b0;
                    if (emit)
                    begin
                        cnt_reg <= cnt_reg + EMIT_CNT_W'(1);
                    end
                end
                else
                begin
                    open_reg <= 1'b1;
                end
                if (finish && end_reg)
                begin
                    bin_reg  <= '0;
                    low_reg  <= '0;
                    high_reg <= s_ext;
                    open_reg <= 1'b0;
                end
            end

            if (finish)
            begin
                busy_reg <= 1'b0;
            end

            if (accept && cfg_live)
            begin
                pos_reg  <= end_in ? '0 : pos_reg + SAMPLE_COUNT_W'(1);
                pn_reg   <= end_in ? '0 : a_in;
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg   <= sample_in.sample;
            a_reg   <= a_in;
            b_reg   <= b_in;
            end_reg <= end_in;
        end
        if (step && !close_now)
        begin
            run_min_reg <= eff_min;
            run_max_reg <= eff_max;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (bin_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit && out_free)
        begin
            out_bin_reg  <= bin_reg;
            out_min_reg  <= eff_min;
            out_max_reg  <= eff_max;
            out_last_reg <= !close_more
                            || (cnt_reg == EMIT_CNT_W'(MAX_BINS_PER_SAMPLE - 1));
            out_done_reg <= (bin_reg == (cfg.bin_count - BIN_COUNT_W'(1)));
        end
    end

    assign bin_out.valid       = out_valid_reg;
    assign bin_out.bin_number  = out_bin_reg;
    assign bin_out.bin_min     = out_min_reg;
    assign bin_out.bin_max     = out_max_reg;
    assign bin_out.last_of_run = out_last_reg;
    assign bin_out.frame_done  = out_done_reg;

endmodule
`default_nettype wire
